@@ hw/rtl/sclu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclu_pkg - shared types and constants for the sorted calibration lookup
// Table size, function codes, register map and the structs passed between
// the register file, the table cells and the top level.
// ----------------------------------------------------------------------------
package sclu_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int DIST_W = 16;
    localparam int LVL_W  = 16;
    localparam int POS_W  = 16;
    localparam int HDG_W  = 9;

    // Config port geometry
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Heading values that flip the sign of the x offset
    localparam logic signed [HDG_W-1:0] HEADING_POS = 9'sd180;
    localparam logic signed [HDG_W-1:0] HEADING_NEG = -9'sd180;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    // Register indexes (word address paddr[3:2])
    typedef enum logic [1:0] {
        REG_ORIGIN_X = 2'd0,
        REG_ORIGIN_Y = 2'd1,
        REG_HEADING  = 2'd2,
        REG_VTL      = 2'd3
    } t_reg_idx;

    // Configuration register contents
    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic signed [HDG_W-1:0] heading;
        logic        [LVL_W-1:0] volt_to_level;
    } t_cfg;

    // Command broadcast to every cell
    typedef struct packed {
        logic              add_we;   // insert a point this cycle
        logic [LVL_W-1:0]  level;    // level of the point to insert
        logic [DIST_W-1:0] distance; // distance of the point to insert
        logic [LVL_W-1:0]  sample;   // sample for the first-match search
    } t_cell_cmd;

    // One table entry
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [LVL_W-1:0]  level;
    } t_entry;

    // First-match search link between neighbor cells
    typedef struct packed {
        logic              found;
        logic [DIST_W-1:0] distance;
    } t_link;

endpackage

@@ hw/rtl/sclu_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclu_regs - configuration register file
// APB-style slave holding sensor origin, heading and voltage scale.
// Zero wait states; reads return the register bits, sign-extended for the signed fields.
// ----------------------------------------------------------------------------
module sclu_regs
    import sclu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    logic     w_wr;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    // Register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_ORIGIN_X: n_cfg.origin_x      = pwdata[POS_W-1:0];
                REG_ORIGIN_Y: n_cfg.origin_y      = pwdata[POS_W-1:0];
                REG_HEADING:  n_cfg.heading       = pwdata[HDG_W-1:0];
                REG_VTL:      n_cfg.volt_to_level = pwdata[LVL_W-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.heading       <= '0;
            r_cfg.volt_to_level <= LVL_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            REG_ORIGIN_X: prdata = DATA_W'(r_cfg.origin_x);
            REG_ORIGIN_Y: prdata = DATA_W'(r_cfg.origin_y);
            REG_HEADING:  prdata = DATA_W'(r_cfg.heading);
            REG_VTL:      prdata = DATA_W'(r_cfg.volt_to_level);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/sclu_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclu_cell - one slot of the sorted calibration table
// Holds one (distance, level) entry. On insert it either keeps its entry,
// takes its left neighbor's entry (shift up) or takes the new point. On query
// it passes the first-match result on to its right neighbor.
// ----------------------------------------------------------------------------
module sclu_cell
    import sclu_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  logic      i_occupied,    // slot index below entry count
    input  logic      i_tail,        // slot index equals entry count
    input  logic      i_left_take,   // left neighbor is at or above new level
    input  t_entry    i_left_entry,
    input  t_link     i_link,
    output logic      o_take,
    output t_entry    o_entry,
    output t_link     o_link
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_hit;

    // Insert point: first slot at or above the new level, or the tail
    assign o_take = i_occupied && (r_entry.level >= i_cmd.level);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.add_we) begin
            if (i_left_take) begin
                n_entry = i_left_entry;
            end else if (o_take || i_tail) begin
                n_entry.distance = i_cmd.distance;
                n_entry.level    = i_cmd.level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

    // First-match chain
    assign w_hit = i_occupied && (r_entry.level >= i_cmd.sample);

    always_comb begin
        o_link.found = i_link.found || w_hit;
        if (i_link.found) begin
            o_link.distance = i_link.distance;
        end else if (w_hit) begin
            o_link.distance = r_entry.distance;
        end else begin
            o_link.distance = '0;
        end
    end

endmodule

@@ hw/rtl/sorted_calibration_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_calibration_lookup - sorted distance calibration table with lookup
// Keeps (distance, level) points in ascending level order and translates a
// converter sample to a distance and an obstacle position.
//
// Request channel (i_valid / o_stall): i_func selects clear, add point,
// query or no operation. Result channel (o_valid / i_stall): exactly one
// result per request, in order. Config goes through the APB-style port; the
// user must write it only while the block is idle, which the block does
// not enforce. The level multiply happens on the way into the request
// register; from there all table cells compare in parallel, shift or
// insert, and the first-match chain feeds the result register.
// Throughput: one request per cycle while the receiver does not stall.
// When the receiver stalls, the held result stays put and one more request
// is taken into the request register; after that o_stall rises.
// Reset empties the table (entry count zero) and loads the register reset
// values; entry contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_calibration_lookup
    import sclu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_func,
    input  logic [DIST_W-1:0]        i_point_distance,
    input  logic [LVL_W-1:0]         i_point_voltage,
    input  logic [LVL_W-1:0]         i_sample_level,
    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_status,
    output logic [DIST_W-1:0]        o_distance,
    output logic signed [POS_W-1:0]  o_obstacle_x,
    output logic signed [POS_W-1:0]  o_obstacle_y,
    output logic signed [HDG_W-1:0]  o_obstacle_heading,
    // config port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    t_cfg w_cfg;

    sclu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ------------------------------------------------------------------
    // Request register (level scaled on entry)
    // ------------------------------------------------------------------
    logic              r_req_valid;
    t_func             r_req_func;
    logic [LVL_W-1:0]  r_req_level;
    logic [DIST_W-1:0] r_req_dist;
    logic [LVL_W-1:0]  r_req_sample;
    logic [2*LVL_W-1:0] w_prod;
    logic              w_in_acc;
    logic              w_out_load;

    assign w_prod     = i_point_voltage * w_cfg.volt_to_level;
    assign w_out_load = r_req_valid && (!o_valid || !i_stall);
    assign o_stall    = r_req_valid && o_valid && i_stall;
    assign w_in_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_req_valid <= 1'b1;
        end else if (w_out_load) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req_func   <= t_func'(i_func);
            r_req_level  <= w_prod[LVL_W-1:0];
            r_req_dist   <= i_point_distance;
            r_req_sample <= i_sample_level;
        end
    end

    // ------------------------------------------------------------------
    // Entry count
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_count;
    logic             w_full;
    logic             w_is_add;
    logic             w_is_query;
    logic             w_is_clear;

    assign w_full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_is_add   = w_out_load && (r_req_func == FUNC_ADD);
    assign w_is_query = w_out_load && (r_req_func == FUNC_QUERY);
    assign w_is_clear = w_out_load && (r_req_func == FUNC_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_is_clear) begin
            r_count <= '0;
        end else if (w_is_add && !w_full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    t_cell_cmd w_cmd;
    logic      w_take  [TABLE_DEPTH];
    t_entry    w_entry [TABLE_DEPTH];
    t_link     w_link  [TABLE_DEPTH+1];

    assign w_cmd.add_we   = w_is_add && !w_full;
    assign w_cmd.level    = r_req_level;
    assign w_cmd.distance = r_req_dist;
    assign w_cmd.sample   = r_req_sample;
    assign w_link[0]      = '0;

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        logic   w_left_take;
        t_entry w_left_entry;

        if (gi == 0) begin : g_head
            assign w_left_take  = 1'b0;
            assign w_left_entry = '0;
        end else begin : g_body
            assign w_left_take  = w_take[gi-1];
            assign w_left_entry = w_entry[gi-1];
        end

        sclu_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_occupied   (CNT_W'(gi) < r_count),
            .i_tail       (CNT_W'(gi) == r_count),
            .i_left_take  (w_left_take),
            .i_left_entry (w_left_entry),
            .i_link       (w_link[gi]),
            .o_take       (w_take[gi]),
            .o_entry      (w_entry[gi]),
            .o_link       (w_link[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                    r_out_valid;
    logic                    r_status;
    logic [DIST_W-1:0]       r_distance;
    logic signed [POS_W-1:0] r_obs_x;
    logic signed [POS_W-1:0] r_obs_y;
    logic signed [HDG_W-1:0] r_obs_hdg;
    logic                    w_flip;
    logic [POS_W-1:0]        w_x;

    assign w_flip = (w_cfg.heading == HEADING_POS) || (w_cfg.heading == HEADING_NEG);
    assign w_x    = w_flip ? (w_cfg.origin_x - w_link[TABLE_DEPTH].distance)
                           : (w_cfg.origin_x + w_link[TABLE_DEPTH].distance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_status <= w_is_add && w_full;
            if (w_is_query) begin
                r_distance <= w_link[TABLE_DEPTH].distance;
                r_obs_x    <= w_x;
                r_obs_y    <= w_cfg.origin_y;
                r_obs_hdg  <= w_cfg.heading;
            end else begin
                r_distance <= '0;
                r_obs_x    <= '0;
                r_obs_y    <= '0;
                r_obs_hdg  <= '0;
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_status;
    assign o_distance         = r_distance;
    assign o_obstacle_x       = r_obs_x;
    assign o_obstacle_y       = r_obs_y;
    assign o_obstacle_heading = r_obs_hdg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_is_add && !w_full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted add did not grow the table");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_is_add && w_full) |=> (o_status && r_count == $past(r_count)))
        else $error("add into a full table not reported or not dropped");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_req_valid && o_valid))
        else $error("request side stalled with a free pipeline");

endmodule
